@@ sv/alir_pkg.sv @@
// Shared types, constants and sequence tables for the ambient light reader.
`timescale 1ns / 1ps
`default_nettype none

package alir_pkg;

  // Input item: one bus timing slot
  typedef struct packed {
    logic [1:0] opcode;
    logic       sda_in;
  } in_item_t;

  // Result item: bus levels and lux reading for one slot
  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_released;
    logic        busy_res;
    logic        lux_valid;
    logic [17:0] lux_value;
  } out_item_t;

  // Configuration registers as seen by the sequencer
  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [7:0]  mode;
    logic [15:0] settle;
  } cfg_t;

  localparam int unsigned PROD_W = 28;
  localparam int unsigned LUX_W  = 18;

  // Sequencer result, registered between sequencer and lux stage
  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_released;
    logic              busy_res;
    logic              lux_valid;
    logic [PROD_W-1:0] lux_prod;
  } slot_t;

  // Opcodes
  localparam logic [1:0] OP_SLOT  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DEV_ADDR = 2'd0;
  localparam logic [1:0] REG_MODE     = 2'd1;
  localparam logic [1:0] REG_SETTLE   = 2'd2;

  localparam logic [6:0]  DEV_ADDR_RST = 7'd74;
  localparam logic [7:0]  MODE_RST     = 8'd0;
  localparam logic [15:0] SETTLE_RST   = 16'd1000;

  // Sequence steps
  localparam logic [4:0] STEP_IDLE    = 5'd0;
  localparam logic [4:0] READ_FIRST   = 5'd1;
  localparam logic [4:0] STEP_RECV_LO = 5'd13;
  localparam logic [4:0] WRITE_FIRST  = 5'd17;
  localparam logic [4:0] NUM_STEPS    = 5'd23;

  localparam logic [7:0] REG_LUX_HI   = 8'h03;
  localparam logic [7:0] REG_LUX_LO   = 8'h04;
  localparam logic [7:0] REG_CONFIG   = 8'h02;
  localparam logic [7:0] MODE_MASK    = 8'h4F;

  // Lux conversion: floor(x * 45 / 1000), divide by reciprocal multiply
  localparam logic [3:0]  EXP_MAX   = 4'hE;
  localparam logic [3:0]  EXP_ONE   = 4'h1;
  localparam logic [15:0] LUX_SCALE = 16'd45;
  localparam int unsigned MAGIC_W   = 29;
  localparam logic [MAGIC_W-1:0] LUX_MAGIC = 29'd274877907;
  localparam int unsigned LUX_SHIFT = 38;
  localparam int unsigned FULL_W    = PROD_W + MAGIC_W;

  typedef enum logic [2:0] {
    K_NONE,
    K_START,
    K_SEND,
    K_RECV,
    K_NACK,
    K_STOP,
    K_SETTLE
  } kind_t;

  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_AW,
    SRC_AR,
    SRC_MODE
  } src_t;

  // Kind of work done in each step
  function automatic kind_t step_kind_f(input logic [4:0] step);
    kind_t k;
    case (step)
      5'd1, 5'd4, 5'd8, 5'd11, 5'd17:               k = K_START;
      5'd2, 5'd3, 5'd5, 5'd9, 5'd10, 5'd12,
      5'd18, 5'd19, 5'd20:                          k = K_SEND;
      5'd6, 5'd13:                                  k = K_RECV;
      5'd7, 5'd14:                                  k = K_NACK;
      5'd15, 5'd21:                                 k = K_STOP;
      5'd16, 5'd22:                                 k = K_SETTLE;
      default:                                      k = K_NONE;
    endcase
    return k;
  endfunction

  // Source of the byte sent in a send step
  function automatic src_t step_src_f(input logic [4:0] step);
    src_t s;
    case (step)
      5'd2, 5'd9, 5'd18: s = SRC_AW;
      5'd5, 5'd12:       s = SRC_AR;
      5'd20:             s = SRC_MODE;
      default:           s = SRC_LIT;
    endcase
    return s;
  endfunction

  // Literal register number for the remaining send steps
  function automatic logic [7:0] step_lit_f(input logic [4:0] step);
    logic [7:0] v;
    case (step)
      5'd3:    v = REG_LUX_HI;
      5'd10:   v = REG_LUX_LO;
      5'd19:   v = REG_CONFIG;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/alir_seq.sv @@
// Slot sequencer: bus levels, transaction steps and lux product per item.
`timescale 1ns / 1ps
`default_nettype none

module alir_seq (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     step_en,
  input  wire alir_pkg::in_item_t item,
  input  wire alir_pkg::cfg_t     cfg,
  output alir_pkg::slot_t         slot
);

  logic [4:0]  step_r,  step_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  hi_byte_r, hi_byte_nxt;
  logic [15:0] settle_r, settle_nxt;

  logic [4:0]  cur_step;
  logic [1:0]  cur_phase;
  logic [3:0]  cur_count;
  logic [4:0]  target;
  logic        enter;
  logic [7:0]  rx_byte;
  logic [3:0]  count_inc;
  alir_pkg::kind_t kind;

  logic [3:0]  exp_raw;
  logic [3:0]  exp_adj;
  logic [7:0]  mant;
  logic [13:0] mant_scaled;

  // Step through the current slot
  always_comb begin
    // fold unused step codes into idle
    if (step_r >= alir_pkg::NUM_STEPS) begin
      cur_step  = alir_pkg::STEP_IDLE;
      cur_phase = '0;
      cur_count = '0;
    end else begin
      cur_step  = step_r;
      cur_phase = phase_r;
      cur_count = count_r;
    end
    if (cur_step == alir_pkg::STEP_IDLE) begin
      if (item.opcode == alir_pkg::OP_READ) begin
        cur_step = alir_pkg::READ_FIRST;
      end else if (item.opcode == alir_pkg::OP_WRITE) begin
        cur_step = alir_pkg::WRITE_FIRST;
      end
    end

    kind        = alir_pkg::step_kind_f(cur_step);
    slot        = '0;
    slot.scl_level = 1'b1;
    slot.sda_level = 1'b1;
    slot.busy_res  = (cur_step != alir_pkg::STEP_IDLE);

    phase_nxt   = cur_phase;
    count_nxt   = cur_count;
    shift_nxt   = shift_r;
    hi_byte_nxt = hi_byte_r;
    settle_nxt  = settle_r;
    enter       = 1'b0;
    target      = cur_step + 5'd1;
    rx_byte     = {shift_r[6:0], item.sda_in};
    count_inc   = cur_count + 4'd1;

    // lux product from the stored high byte and the byte now completing
    exp_raw = hi_byte_r[7:4];
    if (exp_raw == alir_pkg::EXP_ONE) begin
      exp_adj = 4'd0;
    end else if (exp_raw > alir_pkg::EXP_MAX) begin
      exp_adj = alir_pkg::EXP_MAX;
    end else begin
      exp_adj = exp_raw;
    end
    mant          = {hi_byte_r[3:0], rx_byte[3:0]};
    mant_scaled   = 14'(16'(mant) * alir_pkg::LUX_SCALE);
    slot.lux_prod = alir_pkg::PROD_W'(mant_scaled) << exp_adj;

    case (kind)
      alir_pkg::K_START: begin
        slot.sda_level = (cur_phase == 2'd0);
        if (cur_phase >= 2'd1) begin
          enter = 1'b1;
        end else begin
          phase_nxt = 2'd1;
        end
      end
      alir_pkg::K_SEND: begin
        if (cur_count < 4'd8) begin
          slot.scl_level = (cur_phase == 2'd1);
          slot.sda_level = shift_r[7];
          if (cur_phase >= 2'd2) begin
            shift_nxt = {shift_r[6:0], 1'b0};
            count_nxt = count_inc;
            phase_nxt = 2'd0;
          end else begin
            phase_nxt = cur_phase + 2'd1;
          end
        end else begin
          // slave ack: released, sampled and ignored
          slot.sda_released = 1'b1;
          if (cur_phase >= 2'd1) begin
            enter = 1'b1;
          end else begin
            phase_nxt = 2'd1;
          end
        end
      end
      alir_pkg::K_RECV: begin
        slot.sda_released = 1'b1;
        if (cur_phase == 2'd0) begin
          shift_nxt = rx_byte;
          if (cur_count >= 4'd7) begin
            if (cur_step == alir_pkg::STEP_RECV_LO) begin
              slot.lux_valid = 1'b1;
            end else begin
              hi_byte_nxt = rx_byte;
            end
          end
          phase_nxt = 2'd1;
        end else begin
          slot.scl_level = 1'b0;
          count_nxt      = count_inc;
          phase_nxt      = 2'd0;
          if (count_inc >= 4'd8) begin
            enter = 1'b1;
          end
        end
      end
      alir_pkg::K_NACK: begin
        slot.scl_level = (cur_phase == 2'd0);
        if (cur_phase >= 2'd2) begin
          enter = 1'b1;
        end else begin
          phase_nxt = cur_phase + 2'd1;
        end
      end
      alir_pkg::K_STOP: begin
        slot.sda_level = (cur_phase != 2'd0);
        if (cur_phase >= 2'd2) begin
          enter = 1'b1;
          if (cfg.settle == 16'd0) begin
            target = alir_pkg::STEP_IDLE;
          end else begin
            settle_nxt = cfg.settle;
          end
        end else begin
          phase_nxt = cur_phase + 2'd1;
        end
      end
      alir_pkg::K_SETTLE: begin
        if (settle_r <= 16'd1) begin
          settle_nxt = 16'd0;
          enter      = 1'b1;
          target     = alir_pkg::STEP_IDLE;
        end else begin
          settle_nxt = settle_r - 16'd1;
        end
      end
      default: begin
      end
    endcase

    // move to the next step and preload its byte
    if (enter) begin
      step_nxt  = target;
      phase_nxt = 2'd0;
      count_nxt = 4'd0;
      case (alir_pkg::step_kind_f(target))
        alir_pkg::K_SEND: begin
          case (alir_pkg::step_src_f(target))
            alir_pkg::SRC_AW:   shift_nxt = {cfg.dev_addr, 1'b0};
            alir_pkg::SRC_AR:   shift_nxt = {cfg.dev_addr, 1'b1};
            alir_pkg::SRC_MODE: shift_nxt = cfg.mode & alir_pkg::MODE_MASK;
            default:            shift_nxt = alir_pkg::step_lit_f(target);
          endcase
        end
        alir_pkg::K_RECV: shift_nxt = 8'h00;
        default: begin
        end
      endcase
    end else begin
      step_nxt = cur_step;
    end
  end

  // Advance sequencer state once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= alir_pkg::STEP_IDLE;
      phase_r  <= '0;
      count_r  <= '0;
      shift_r  <= '0;
      settle_r <= '0;
    end else if (step_en) begin
      step_r   <= step_nxt;
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      shift_r  <= shift_nxt;
      settle_r <= settle_nxt;
    end
  end

  // High register byte is always written before it is used
  always_ff @(posedge clk) begin
    if (step_en) begin
      hi_byte_r <= hi_byte_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/alir_lux.sv @@
// Lux scaling: divide the product by 1000 and hold the last reading.
`timescale 1ns / 1ps
`default_nettype none

module alir_lux (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             upd,
  input  wire  [alir_pkg::PROD_W-1:0]     prod,
  output logic [alir_pkg::LUX_W-1:0]      lux_nxt
);

  logic [alir_pkg::FULL_W-1:0] full;
  logic [alir_pkg::LUX_W-1:0]  quot;
  logic [alir_pkg::LUX_W-1:0]  lux_r;

  // Reciprocal multiply, exact for every product below 1000 * 2^18
  always_comb begin
    full = alir_pkg::FULL_W'(prod) * alir_pkg::FULL_W'(alir_pkg::LUX_MAGIC);
    quot = full[alir_pkg::LUX_SHIFT + alir_pkg::LUX_W - 1 : alir_pkg::LUX_SHIFT];
    lux_nxt = upd ? quot : lux_r;
  end

  // Hold the last converted value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lux_r <= '0;
    end else if (upd) begin
      lux_r <= quot;
    end
  end

endmodule

`default_nettype wire

@@ sv/ambient_light_i2c_reader.sv @@
// Top level: item pipeline, configuration registers, sequencer and lux stage.
//
// Bit-banged I2C master for an ambient light sensor. Each input item on the
// in_ channel is one bus timing slot carrying an opcode (plain slot, start
// lux read, start mode write) and the sampled SDA level. Every accepted item
// yields exactly one result item on the out_ channel with the SCL/SDA levels
// for that slot, the SDA release flag, busy, and the lux reading (lux_valid
// marks the slot in which a new reading completes).
// Configuration writes on the cfg_ port are always taken (cfg_ready is high)
// and should only be made while the block is idle.
// An item accepted on the in_ channel passes the input register, the
// sequencer register and the output register before it shows on the out_
// channel. One item per cycle is sustained while out_stall is low; the
// sequencer updates its state once per slot.
// Each stage refills whenever the stage after it is empty or moving, so the
// block keeps taking items while a result waits under out_stall until all
// three stages are full, then raises in_stall.
// Synchronous reset returns the sequencer to idle, empties the pipeline,
// clears the lux reading and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module ambient_light_i2c_reader (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire alir_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire                      out_stall,
  output alir_pkg::out_item_t      out_item,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [1:0]               cfg_index,
  input  wire  [15:0]              cfg_data
);

  logic                s1_vld_r;
  alir_pkg::in_item_t  s1_item_r;
  logic                s2_vld_r;
  alir_pkg::slot_t     s2_r;
  logic                out_vld_r;
  alir_pkg::out_item_t out_r;

  logic                adv1, adv2, adv3;
  alir_pkg::cfg_t      cfg_r;
  alir_pkg::slot_t     seq_slot;
  logic                lux_upd;
  logic [alir_pkg::LUX_W-1:0] lux_nxt;

  // Stage enables: a stage moves when the next one is empty or moving
  assign adv3 = !out_vld_r || !out_stall;
  assign adv2 = !s2_vld_r || adv3;
  assign adv1 = !s1_vld_r || adv2;

  assign in_stall  = !adv1;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr <= alir_pkg::DEV_ADDR_RST;
      cfg_r.mode     <= alir_pkg::MODE_RST;
      cfg_r.settle   <= alir_pkg::SETTLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        alir_pkg::REG_DEV_ADDR: cfg_r.dev_addr <= cfg_data[6:0];
        alir_pkg::REG_MODE:     cfg_r.mode     <= cfg_data[7:0];
        alir_pkg::REG_SETTLE:   cfg_r.settle   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv1) s1_vld_r  <= in_valid;
      if (adv2) s2_vld_r  <= s1_vld_r;
      if (adv3) out_vld_r <= s2_vld_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_item_r <= in_item;
    end
    if (adv2) begin
      s2_r <= seq_slot;
    end
    if (adv3) begin
      out_r.scl_level    <= s2_r.scl_level;
      out_r.sda_level    <= s2_r.sda_level;
      out_r.sda_released <= s2_r.sda_released;
      out_r.busy_res     <= s2_r.busy_res;
      out_r.lux_valid    <= s2_r.lux_valid;
      out_r.lux_value    <= lux_nxt;
    end
  end

  alir_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_vld_r && adv2),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .slot    (seq_slot)
  );

  assign lux_upd = adv3 && s2_vld_r && s2_r.lux_valid;

  alir_lux u_lux (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (lux_upd),
    .prod    (s2_r.lux_prod),
    .lux_nxt (lux_nxt)
  );

endmodule

`default_nettype wire

@@ sv/alir_checker.sv @@
// Port-level checks for the ambient light reader, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module alir_checker (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      out_valid,
  input  wire                      out_stall,
  input  wire alir_pkg::out_item_t out_item
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // Idle slots leave the bus free
  a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.busy_res |->
      out_item.scl_level && out_item.sda_level && !out_item.sda_released)
    else $error("bus not free in idle slot");

  // A reading completes only in a released read slot of a transaction
  a_lux_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.lux_valid |->
      out_item.sda_released && out_item.busy_res && out_item.scl_level)
    else $error("lux reading outside a read bit slot");

  // SDA is only released during a transaction
  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.sda_released |-> out_item.busy_res)
    else $error("data line released while idle");

endmodule

bind ambient_light_i2c_reader alir_checker u_alir_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
